### hw/rtl/rgse_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the swell envelope generator
// no dependencies; imported by rgse_cfg, the top and the bench

package rgse_pkg;

    // fixed point
    localparam int FRAC_BITS_DEF = 40;
    localparam int Q16_W         = 17;
    localparam int FS_W          = 18;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_GATE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_SWELL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DENSITY = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHAPE   = 3'd3;
    localparam logic [IDX_W-1:0] REG_FS      = 3'd4;

    // register reset values
    localparam logic [Q16_W-1:0] GATE_RST    = 17'd0;
    localparam logic [Q16_W-1:0] SWELL_RST   = 17'd26214;
    localparam logic [Q16_W-1:0] DENSITY_RST = 17'd49152;
    localparam logic [Q16_W-1:0] SHAPE_RST   = 17'd21627;
    localparam logic [FS_W-1:0]  FS_RST      = 18'd48000;

    // arithmetic constants
    localparam logic [Q16_W-1:0] Q16_ONE     = 17'd65536;
    localparam logic [Q16_W-1:0] GATE_THRESH = 17'd655;
    localparam logic [15:0]      K_065_Q16   = 16'd42598;
    localparam int TICK_W    = 32;
    localparam int RISE_W    = 19;
    localparam int REL_W     = 18;
    localparam int SQ_W      = 38;
    localparam int MUL_B_W   = 22;
    localparam int DIV_DEN_W = 45;
    localparam int GAP_DIV   = 50;
    localparam int MIN_LEN   = 2;

    // reciprocal constants: ceil(2^24/50) exact for an 18-bit rate,
    // ceil(2^24/5) exact for a 22-bit scaled length
    localparam logic [MUL_B_W-1:0] GAP_RECIP = 22'd335545;
    localparam logic [MUL_B_W-1:0] LEN_RECIP = 22'd3355444;
    localparam int RECIP_SHIFT = 24;
    localparam int RISE_SHIFT  = 18;
    localparam int REL_SHIFT   = 17;

    // envelope phase codes
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_RISE   = 2'd1,
        PH_SETTLE = 2'd2
    } phase_t;

    // configuration register set
    typedef struct packed {
        logic [Q16_W-1:0] gate_amount;
        logic [Q16_W-1:0] swell_length;
        logic [Q16_W-1:0] hold_density;
        logic [Q16_W-1:0] attack_shape;
        logic [FS_W-1:0]  sample_rate_hz;
    } cfg_t;

    // clamp a q16 control to 1.0
    function automatic logic [Q16_W-1:0] sat_q16(input logic [Q16_W-1:0] v);
        return (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

endpackage

### hw/rtl/rgse_mul.sv
`timescale 1ns / 1ps
// shared multiplier with a registered product
// depends on nothing; used by the envelope sequencer

module rgse_mul #(
    parameter int AW = 41,
    parameter int BW = 22
) (
    input  logic             clk,
    input  logic [AW-1:0]    op_a,
    input  logic [BW-1:0]    op_b,
    output logic [AW+BW-1:0] product
);

    logic [AW+BW-1:0] prod_reg;
    logic [AW+BW-1:0] prod_next;

    // full-width unsigned product
    assign prod_next = {{BW{1'b0}}, op_a} * {{AW{1'b0}}, op_b};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

### hw/rtl/rgse_div.sv
`timescale 1ns / 1ps
// shared restoring divider, one quotient bit per cycle
// depends on nothing; used by the envelope sequencer

module rgse_div #(
    parameter int DW = 57,
    parameter int VW = 45
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    // iteration control
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hw/rtl/rgse_cfg.sv
`timescale 1ns / 1ps
// apb-style configuration registers of the swell envelope generator
// depends on rgse_pkg

module rgse_cfg
    import rgse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg, cfg_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GATE:    cfg_next.gate_amount    = pwdata[Q16_W-1:0];
                REG_SWELL:   cfg_next.swell_length   = pwdata[Q16_W-1:0];
                REG_DENSITY: cfg_next.hold_density   = pwdata[Q16_W-1:0];
                REG_SHAPE:   cfg_next.attack_shape   = pwdata[Q16_W-1:0];
                REG_FS:      cfg_next.sample_rate_hz = pwdata[FS_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_GATE:    prdata = DATA_W'(cfg_reg.gate_amount);
            REG_SWELL:   prdata = DATA_W'(cfg_reg.swell_length);
            REG_DENSITY: prdata = DATA_W'(cfg_reg.hold_density);
            REG_SHAPE:   prdata = DATA_W'(cfg_reg.attack_shape);
            REG_FS:      prdata = DATA_W'(cfg_reg.sample_rate_hz);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_amount    <= GATE_RST;
            cfg_reg.swell_length   <= SWELL_RST;
            cfg_reg.hold_density   <= DENSITY_RST;
            cfg_reg.attack_shape   <= SHAPE_RST;
            cfg_reg.sample_rate_hz <= FS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/reverse_gate_swell_envelope_top.sv
`timescale 1ns / 1ps
// swell envelope generator top: sequencer over a shared multiplier and divider
// depends on rgse_pkg, rgse_cfg, rgse_mul, rgse_div
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall   onset
//   out      source     out_valid / out_stall envelope_gain, phase, retriggered
//   cfg      sink       apb write/read        5 registers at byte address 4*i
//
// a sample without a retrigger test goes straight from idle to the update; an onset
// that fails the gap test first passes through the gap multiply and check; a retrigger
// also computes both lengths and makes three passes through the one-bit-per-cycle divider.
// in_stall is high while a sample is in work, including any cycles that a
// waiting result holds the update; the next sample is taken while a result
// still waits in the output register.
// reset restores the envelope to 1.0, idle, and clears counters and steps.

module reverse_gate_swell_envelope_top
    import rgse_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              onset,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [Q16_W-1:0]  envelope_gain,
    output logic [1:0]        phase,
    output logic              retriggered,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int LW = FRAC_BITS + 1;
    localparam int SW = FRAC_BITS + 8;
    localparam int DW = FRAC_BITS + 17;
    localparam int VW = DIV_DEN_W;
    localparam int MA = LW;
    localparam int MB = MUL_B_W;
    localparam int PW = MA + MB;

    localparam logic [LW-1:0] ONE_Q     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [LW-1:0] FLOOR_MIN = ONE_Q / LW'(5);
    localparam logic [LW-1:0] SPAN_MIN  = ONE_Q / LW'(10000);
    localparam logic [SW-1:0] STEP_MAX  = {SW{1'b1}};

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GAP_MUL,
        ST_GAP_CHK,
        ST_RISE_MUL,
        ST_RISE_RCP,
        ST_RISE_LEN,
        ST_REL_MUL,
        ST_REL_RCP,
        ST_REL_LEN,
        ST_SQ_MUL,
        ST_STEP_MUL,
        ST_STEP_DIV,
        ST_STEP_WAIT,
        ST_ACC_MUL,
        ST_ACC_DIV,
        ST_ACC_WAIT,
        ST_FALL_DIV,
        ST_FALL_WAIT,
        ST_UPDATE
    } state_t;

    cfg_t cfg;

    // sequencer and envelope state
    state_t              state_reg, state_next;
    logic [LW-1:0]       level_reg, level_next;
    phase_t              phase_reg, phase_next;
    logic [SW-1:0]       rise_step_reg, rise_step_next;
    logic [SW-1:0]       accel_reg, accel_next;
    logic [SW-1:0]       fall_step_reg, fall_step_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [TICK_W-1:0]   last_reg, last_next;
    logic [LW-1:0]       fl_reg, fl_next;
    logic                active_reg, active_next;
    logic                retrig_reg, retrig_next;
    logic [RISE_W-1:0]   rise_reg, rise_next;
    logic [REL_W-1:0]    rel_reg, rel_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [Q16_W-1:0]    gain_out_reg, gain_out_next;
    logic [1:0]          phase_out_reg, phase_out_next;
    logic                retrig_out_reg, retrig_out_next;

    // shared unit connections
    logic [MA-1:0]       mul_a;
    logic [MB-1:0]       mul_b;
    logic [PW-1:0]       mul_p;
    logic                div_start;
    logic [DW-1:0]       div_num;
    logic [VW-1:0]       div_den;
    logic                div_done;
    logic [DW-1:0]       div_quot;

    // config-derived values
    logic [Q16_W-1:0]    g_sat;
    logic [31:0]         gate_mul;
    logic [47:0]         gate_prod48;
    logic [FRAC_BITS-1:0] drop;
    logic [LW-1:0]       floor_raw;
    logic [LW-1:0]       floor_cur;
    logic                active_cur;
    logic [MB-1:0]       k_rise;
    logic [MB-1:0]       k_rel;
    logic [Q16_W-1:0]    shape;
    logic [Q16_W-1:0]    shape_inv;

    // per-sample working values
    logic [LW-1:0]       level_gap;
    logic [LW-1:0]       span;
    logic [TICK_W-1:0]   gap;
    logic [PW-1:0]       len_quot;
    logic [FRAC_BITS-1:0] mv_rise;
    logic [FRAC_BITS-1:0] mv_fall;
    logic [LW:0]         rise_sum;
    logic [SW:0]         step_sum;
    logic [LW:0]         fall_lim;
    logic                out_free;

    rgse_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rgse_mul #(
        .AW (MA),
        .BW (MB)
    ) u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    rgse_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quot)
    );

    // floor and gate activity from the gate depth
    assign g_sat       = sat_q16(cfg.gate_amount);
    assign gate_mul    = 32'(g_sat) * 32'(K_065_Q16);
    assign gate_prod48 = {gate_mul, 16'd0};
    assign drop        = gate_prod48[47 -: FRAC_BITS];
    assign floor_raw   = ONE_Q - LW'(drop);
    assign floor_cur   = (floor_raw < FLOOR_MIN) ? FLOOR_MIN : floor_raw;
    assign active_cur  = g_sat > GATE_THRESH;

    // length numerators and attack blend weights
    assign k_rise    = MB'(Q16_ONE) + MB'(sat_q16(cfg.swell_length)) * MB'(39);
    assign k_rel     = MB'(196608) + MB'(sat_q16(cfg.hold_density)) * MB'(7);
    assign shape     = sat_q16(cfg.attack_shape);
    assign shape_inv = Q16_ONE - shape;

    // rise span from the current level, or from the floor when idle
    assign level_gap = (level_reg >= ONE_Q) ? '0 : ONE_Q - level_reg;
    always_comb
    begin
        if (phase_reg == PH_RISE || phase_reg == PH_SETTLE)
        begin
            span = (level_gap < SPAN_MIN) ? SPAN_MIN : level_gap;
        end
        else
        begin
            span = ONE_Q - fl_reg;
        end
    end

    assign gap = tick_reg - last_reg;

    // quotient of a reciprocal multiply
    assign len_quot = mul_p >> RECIP_SHIFT;

    // per-sample moves, at least one lsb
    assign mv_rise = (rise_step_reg[SW-1:8] == '0) ? FRAC_BITS'(1) : rise_step_reg[SW-1:8];
    assign mv_fall = (fall_step_reg[SW-1:8] == '0) ? FRAC_BITS'(1) : fall_step_reg[SW-1:8];
    assign rise_sum = (LW+1)'(level_reg) + (LW+1)'(mv_rise);
    assign step_sum = (SW+1)'(rise_step_reg) + (SW+1)'(accel_reg);
    assign fall_lim = (LW+1)'(fl_reg) + (LW+1)'(mv_fall);

    assign out_free = !out_valid_reg || !out_stall;

    // multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_GAP_MUL:
            begin
                mul_a = MA'(cfg.sample_rate_hz);
                mul_b = GAP_RECIP;
            end
            ST_RISE_MUL:
            begin
                mul_a = MA'(cfg.sample_rate_hz);
                mul_b = k_rise;
            end
            ST_RISE_RCP:
            begin
                mul_a = MA'(mul_p >> RISE_SHIFT);
                mul_b = LEN_RECIP;
            end
            ST_REL_MUL:
            begin
                mul_a = MA'(cfg.sample_rate_hz);
                mul_b = k_rel;
            end
            ST_REL_RCP:
            begin
                mul_a = MA'(mul_p >> REL_SHIFT);
                mul_b = LEN_RECIP;
            end
            ST_SQ_MUL:
            begin
                mul_a = MA'(rise_reg);
                mul_b = MB'(rise_reg);
            end
            ST_STEP_MUL:
            begin
                mul_a = span;
                mul_b = MB'(shape_inv);
            end
            ST_ACC_MUL:
            begin
                mul_a = span;
                mul_b = MB'(shape);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operand select and start
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_STEP_DIV:
            begin
                div_start = 1'b1;
                div_num   = DW'(mul_p);
                div_den   = VW'({rise_reg, 8'd0});
            end
            ST_ACC_DIV:
            begin
                div_start = 1'b1;
                div_num   = DW'(mul_p);
                div_den   = VW'({sq_reg, 7'd0});
            end
            ST_FALL_DIV:
            begin
                div_start = 1'b1;
                div_num   = DW'({ONE_Q - fl_reg, 8'd0});
                div_den   = VW'(rel_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        level_next      = level_reg;
        phase_next      = phase_reg;
        rise_step_next  = rise_step_reg;
        accel_next      = accel_reg;
        fall_step_next  = fall_step_reg;
        tick_next       = tick_reg;
        last_next       = last_reg;
        fl_next         = fl_reg;
        active_next     = active_reg;
        retrig_next     = retrig_reg;
        rise_next       = rise_reg;
        rel_next        = rel_reg;
        sq_next         = sq_reg;
        out_valid_next  = out_valid_reg && out_stall;
        gain_out_next   = gain_out_reg;
        phase_out_next  = phase_out_reg;
        retrig_out_next = retrig_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    tick_next   = tick_reg + TICK_W'(1);
                    fl_next     = floor_cur;
                    active_next = active_cur;
                    retrig_next = 1'b0;
                    state_next  = (onset && active_cur) ? ST_GAP_MUL : ST_UPDATE;
                end
            end
            ST_GAP_MUL:
            begin
                state_next = ST_GAP_CHK;
            end
            ST_GAP_CHK:
            begin
                state_next = (PW'(gap) >= len_quot) ? ST_RISE_MUL : ST_UPDATE;
            end
            ST_RISE_MUL:
            begin
                state_next = ST_RISE_RCP;
            end
            ST_RISE_RCP:
            begin
                state_next = ST_RISE_LEN;
            end
            ST_RISE_LEN:
            begin
                rise_next  = (len_quot < PW'(MIN_LEN)) ? RISE_W'(MIN_LEN)
                                                       : len_quot[RISE_W-1:0];
                state_next = ST_REL_MUL;
            end
            ST_REL_MUL:
            begin
                state_next = ST_REL_RCP;
            end
            ST_REL_RCP:
            begin
                state_next = ST_REL_LEN;
            end
            ST_REL_LEN:
            begin
                rel_next   = (len_quot < PW'(MIN_LEN)) ? REL_W'(MIN_LEN)
                                                       : len_quot[REL_W-1:0];
                state_next = ST_SQ_MUL;
            end
            ST_SQ_MUL:
            begin
                state_next = ST_STEP_MUL;
            end
            ST_STEP_MUL:
            begin
                sq_next    = mul_p[SQ_W-1:0];
                state_next = ST_STEP_DIV;
            end
            ST_STEP_DIV:
            begin
                state_next = ST_STEP_WAIT;
            end
            ST_STEP_WAIT:
            begin
                if (div_done)
                begin
                    rise_step_next = (div_quot[DW-1:SW] != '0) ? STEP_MAX
                                                               : div_quot[SW-1:0];
                    state_next     = ST_ACC_MUL;
                end
            end
            ST_ACC_MUL:
            begin
                state_next = ST_ACC_DIV;
            end
            ST_ACC_DIV:
            begin
                state_next = ST_ACC_WAIT;
            end
            ST_ACC_WAIT:
            begin
                if (div_done)
                begin
                    accel_next = (div_quot[DW-1:SW] != '0) ? STEP_MAX : div_quot[SW-1:0];
                    state_next = ST_FALL_DIV;
                end
            end
            ST_FALL_DIV:
            begin
                state_next = ST_FALL_WAIT;
            end
            ST_FALL_WAIT:
            begin
                if (div_done)
                begin
                    fall_step_next = div_quot[SW-1:0];
                    phase_next     = PH_RISE;
                    last_next      = tick_reg;
                    retrig_next    = 1'b1;
                    state_next     = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    // envelope update for this sample
                    if (active_reg)
                    begin
                        case (phase_reg)
                            PH_RISE:
                            begin
                                rise_step_next = (step_sum > (SW+1)'(STEP_MAX))
                                                 ? STEP_MAX : step_sum[SW-1:0];
                                if (rise_sum >= (LW+1)'(ONE_Q))
                                begin
                                    level_next = ONE_Q;
                                    phase_next = PH_SETTLE;
                                end
                                else
                                begin
                                    level_next = rise_sum[LW-1:0];
                                end
                            end
                            PH_SETTLE:
                            begin
                                if ((LW+1)'(level_reg) <= fall_lim)
                                begin
                                    level_next = fl_reg;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    level_next = level_reg - LW'(mv_fall);
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        level_next = ONE_Q;
                        phase_next = PH_IDLE;
                    end
                    // load the output register
                    out_valid_next  = 1'b1;
                    gain_out_next   = level_next[FRAC_BITS -: Q16_W];
                    phase_out_next  = phase_next;
                    retrig_out_next = retrig_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            level_reg      <= ONE_Q;
            phase_reg      <= PH_IDLE;
            rise_step_reg  <= '0;
            accel_reg      <= '0;
            fall_step_reg  <= '0;
            tick_reg       <= '0;
            last_reg       <= '0;
            fl_reg         <= ONE_Q;
            active_reg     <= 1'b0;
            retrig_reg     <= 1'b0;
            rise_reg       <= '0;
            rel_reg        <= '0;
            sq_reg         <= '0;
            out_valid_reg  <= 1'b0;
            gain_out_reg   <= '0;
            phase_out_reg  <= '0;
            retrig_out_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            phase_reg      <= phase_next;
            rise_step_reg  <= rise_step_next;
            accel_reg      <= accel_next;
            fall_step_reg  <= fall_step_next;
            tick_reg       <= tick_next;
            last_reg       <= last_next;
            fl_reg         <= fl_next;
            active_reg     <= active_next;
            retrig_reg     <= retrig_next;
            rise_reg       <= rise_next;
            rel_reg        <= rel_next;
            sq_reg         <= sq_next;
            out_valid_reg  <= out_valid_next;
            gain_out_reg   <= gain_out_next;
            phase_out_reg  <= phase_out_next;
            retrig_out_reg <= retrig_out_next;
        end
    end

    // a new sample is taken only by the idle sequencer
    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign envelope_gain = gain_out_reg;
    assign phase         = phase_out_reg;
    assign retriggered   = retrig_out_reg;

endmodule

### bench/tb_reverse_gate_swell_envelope_top.sv
`timescale 1ns / 1ps
// self-checking bench for the swell envelope generator: onset samples in, gain out
// depends on rgse_pkg and reverse_gate_swell_envelope_top

module tb_reverse_gate_swell_envelope_top;
    import rgse_pkg::*;

    localparam int        FRAC      = FRAC_BITS_DEF;
    localparam bit [63:0] ONE_FX    = 64'd1 << FRAC;
    localparam bit [63:0] STEP_CAP  = (64'd1 << (FRAC + 8)) - 64'd1;
    localparam int        RAND_GOAL = 1250;
    // far above the slowest legal run, with retriggers and stalls throughout
    localparam int        CYCLE_LIMIT = 4_000_000;
    localparam int        LONG_HOLD   = 300;
    localparam int        HOLD_EVERY  = 4000;

    // register indexes past the end of the register list
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        bit [Q16_W-1:0] gain;
        phase_t         ph;
        bit             fired;
    } envelope_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              onset = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [Q16_W-1:0]  envelope_gain;
    logic [1:0]        phase;
    logic              retriggered;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    reverse_gate_swell_envelope_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .onset         (onset),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .envelope_gain (envelope_gain),
        .phase         (phase),
        .retriggered   (retriggered),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // predictor copy of the registers
    bit [63:0] gate_q16    = 64'd0;
    bit [63:0] swell_q16   = 64'd26214;
    bit [63:0] density_q16 = 64'd49152;
    bit [63:0] shape_q16   = 64'd21627;
    bit [63:0] rate_hz     = 64'd48000;

    // predictor copy of the envelope state
    bit [63:0] level_fx      = ONE_FX;
    phase_t    lvl_phase     = PH_IDLE;
    bit [63:0] climb_step    = 64'd0;
    bit [63:0] climb_accel   = 64'd0;
    bit [63:0] drop_step     = 64'd0;
    bit [31:0] tick_count    = 32'd0;
    bit [31:0] last_fire_tick = 32'd0;

    bit               onset_queue[$];
    envelope_result_t gain_expect[$];
    envelope_result_t want;

    int errors = 0;
    int cycles = 0;
    int burst_left = 8;
    int gap_left = 0;
    int hold_left = 0;
    int since_hold = 0;
    int stretch_left = 0;
    int stall_pct = 0;

    // clamp a q16 control at 1.0
    function automatic bit [63:0] clamp_unit(input bit [63:0] v);
        return (v > 64'd65536) ? 64'd65536 : v;
    endfunction

    // gain floor for a gate depth, never below 0.2
    function automatic bit [63:0] floor_of(input bit [63:0] g);
        bit [63:0] drop;
        bit [63:0] f;
        drop = ((g * K_065_Q16) << 16) >> (48 - FRAC);
        f = (drop >= ONE_FX) ? 64'd0 : ONE_FX - drop;
        if (f < ONE_FX / 5)
            f = ONE_FX / 5;
        return f;
    endfunction

    // per-sample level change, at least one lsb
    function automatic bit [63:0] nudge(input bit [63:0] step);
        return ((step >> 8) == 64'd0) ? 64'd1 : (step >> 8);
    endfunction

    // advance the envelope by one sample and queue the expected gain
    function automatic void step_envelope(input bit onset_in);
        bit [63:0]        g;
        bit [63:0]        fl;
        bit [63:0]        fs;
        bit [63:0]        rise_len;
        bit [63:0]        fall_len;
        bit [63:0]        shp;
        bit [63:0]        span;
        bit [63:0]        d;
        bit [63:0]        gain;
        bit [31:0]        gap;
        bit               active;
        bit               fired;
        envelope_result_t res;
        g = clamp_unit(gate_q16);
        fl = floor_of(g);
        active = g > GATE_THRESH;
        fired = 1'b0;
        fs = rate_hz;
        tick_count = tick_count + 32'd1;

        // retrigger once the minimum spacing has passed
        if (onset_in && active) begin
            gap = tick_count - last_fire_tick;
            if ({32'd0, gap} >= fs / GAP_DIV) begin
                rise_len = fs * (64'd65536 + 64'd39 * clamp_unit(swell_q16)) / 64'd1310720;
                fall_len = fs * (64'd196608 + 64'd7 * clamp_unit(density_q16)) / 64'd655360;
                shp = clamp_unit(shape_q16);
                if (rise_len < MIN_LEN)
                    rise_len = MIN_LEN;
                if (fall_len < MIN_LEN)
                    fall_len = MIN_LEN;
                if (lvl_phase == PH_RISE || lvl_phase == PH_SETTLE)
                begin
                    span = (level_fx >= ONE_FX) ? 64'd0 : ONE_FX - level_fx;
                    if (span < ONE_FX / 10000)
                        span = ONE_FX / 10000;
                end
                else
                begin
                    span = ONE_FX - fl;
                end
                climb_step = span * (64'd65536 - shp) / (64'd256 * rise_len);
                climb_accel = span * shp / (64'd128 * rise_len * rise_len);
                if (climb_step > STEP_CAP)
                    climb_step = STEP_CAP;
                if (climb_accel > STEP_CAP)
                    climb_accel = STEP_CAP;
                drop_step = ((ONE_FX - fl) << 8) / fall_len;
                lvl_phase = PH_RISE;
                last_fire_tick = tick_count;
                fired = 1'b1;
            end
        end

        // envelope update
        if (active)
        begin
            if (lvl_phase == PH_RISE)
            begin
                level_fx = level_fx + nudge(climb_step);
                climb_step = climb_step + climb_accel;
                if (climb_step > STEP_CAP)
                    climb_step = STEP_CAP;
                if (level_fx >= ONE_FX)
                begin
                    level_fx = ONE_FX;
                    lvl_phase = PH_SETTLE;
                end
            end
            else if (lvl_phase == PH_SETTLE)
            begin
                d = nudge(drop_step);
                if (level_fx <= fl + d)
                begin
                    level_fx = fl;
                    lvl_phase = PH_IDLE;
                end
                else
                begin
                    level_fx = level_fx - d;
                end
            end
            else
            begin
                lvl_phase = PH_IDLE;
            end
        end
        else
        begin
            level_fx = ONE_FX;
            lvl_phase = PH_IDLE;
        end

        gain = level_fx >> (FRAC - 16);
        if (gain > 64'd65536)
            gain = 64'd65536;
        res.gain = gain[Q16_W-1:0];
        res.ph = lvl_phase;
        res.fired = fired;
        gain_expect.push_back(res);
    endfunction

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_reverse_gate_swell_envelope_top failed");
            $finish;
        end
    end

    // sample driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                step_envelope(onset);
                onset_queue.delete(0);
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (onset_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    onset <= onset_queue[0];
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern, with a long hold now and then while samples are offered
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (since_hold >= HOLD_EVERY && in_valid)
            begin
                out_stall <= 1'b1;
                hold_left = LONG_HOLD;
                since_hold = 0;
            end
            else
            begin
                since_hold++;
                if (stretch_left <= 0)
                begin
                    stretch_left = $urandom_range(10, 200);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 20;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                stretch_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (gain_expect.size() == 0)
            begin
                $error("unexpected transaction: envelope_gain %0d phase %0d retriggered %0d",
                       envelope_gain, phase, retriggered);
                errors++;
            end
            else
            begin
                want = gain_expect.pop_front();
                if (envelope_gain !== want.gain)
                begin
                    $error("envelope_gain expected %0d actual %0d", want.gain, envelope_gain);
                    errors++;
                end
                if (phase !== want.ph)
                begin
                    $error("phase expected %0d actual %0d", want.ph, phase);
                    errors++;
                end
                if (retriggered !== want.fired)
                begin
                    $error("retriggered expected %0d actual %0d", want.fired, retriggered);
                    errors++;
                end
            end
        end
    end

    // register write, then read back where the register exists
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] stored;
        logic [DATA_W-1:0] got;
        bit                known;
        known = 1'b1;
        stored = {15'd0, value[Q16_W-1:0]};
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GATE:    gate_q16 = value[Q16_W-1:0];
            REG_SWELL:   swell_q16 = value[Q16_W-1:0];
            REG_DENSITY: density_q16 = value[Q16_W-1:0];
            REG_SHAPE:   shape_q16 = value[Q16_W-1:0];
            REG_FS:
            begin
                rate_hz = value[FS_W-1:0];
                stored = {14'd0, value[FS_W-1:0]};
            end
            default:     known = 1'b0;
        endcase
        if (known)
        begin
            @(posedge clk);
            psel <= 1'b1;
            paddr <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            got = prdata;
            psel <= 1'b0;
            penable <= 1'b0;
            if (got !== stored)
            begin
                $error("prdata expected %0d actual %0d", stored, got);
                errors++;
            end
        end
    endtask

    // wait until every sample is taken and every gain has come back
    task automatic drain();
        while (onset_queue.size() != 0 || gain_expect.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // queue a fixed onset pattern, lsb first, and let it finish
    task automatic send_pattern(input bit [15:0] pat, input int n);
        for (int i = 0; i < n; i++)
            onset_queue.push_back(pat[i]);
        drain();
    endtask

    function automatic logic [DATA_W-1:0] pick_q16();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd65536;
            2: return 32'd65536 + $urandom_range(1, 65535);
            3: return $urandom;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_gate();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd655;
            2: return 32'd656;
            3: return 32'd65536;
            4: return 32'd65536 + $urandom_range(1, 65535);
            default: return $urandom_range(657, 65536);
        endcase
    endfunction

    // mostly tiny rates so that swells are short and retriggers frequent
    function automatic logic [DATA_W-1:0] pick_rate();
        case ($urandom_range(0, 19))
            12, 13, 14: return $urandom_range(150, 2000);
            15: return 32'd8000;
            16: return 32'd192000;
            17: return $urandom_range(8000, 192000);
            18: return 32'd262143;
            19: return 32'd0;
            default: return $urandom_range(0, 150);
        endcase
    endfunction

    // stimulus
    initial
    begin
        int random_sent;
        int n;
        int pct;
        random_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // onset right after reset falls inside the minimum spacing
        cfg_write(REG_GATE, 32'd65536);
        cfg_write(REG_FS, 32'd48000);
        send_pattern(16'b01, 2);

        // gate off forces unity gain
        cfg_write(REG_GATE, 32'd0);
        send_pattern(16'b01, 2);

        // zero rate: shortest swells, onsets during rise and settle
        cfg_write(REG_GATE, 32'd65536);
        cfg_write(REG_FS, 32'd0);
        cfg_write(REG_SWELL, 32'd0);
        cfg_write(REG_DENSITY, 32'd0);
        cfg_write(REG_SHAPE, 32'd0);
        send_pattern(16'b0001_1001, 8);

        // gate exactly at the threshold is still off
        cfg_write(REG_GATE, 32'd655);
        send_pattern(16'b11, 2);

        // just above threshold, saturated controls, quadratic attack, spare addresses
        cfg_write(REG_GATE, 32'd656);
        cfg_write(REG_FS, 32'd150);
        cfg_write(REG_SWELL, 32'd131071);
        cfg_write(REG_DENSITY, 32'hFFFF_FFFF);
        cfg_write(REG_SHAPE, 32'd65536);
        cfg_write(REG_SPARE_LO, $urandom);
        cfg_write(REG_SPARE_HI, $urandom);
        send_pattern(16'b1011_0001, 8);

        // random phases
        while (random_sent < RAND_GOAL)
        begin
            cfg_write(REG_GATE, pick_gate());
            if ($urandom_range(0, 1))
                cfg_write(REG_FS, pick_rate());
            if ($urandom_range(0, 1))
                cfg_write(REG_SWELL, pick_q16());
            if ($urandom_range(0, 1))
                cfg_write(REG_DENSITY, pick_q16());
            if ($urandom_range(0, 1))
                cfg_write(REG_SHAPE, pick_q16());
            if ($urandom_range(0, 7) == 0)
                cfg_write(IDX_W'(REG_SPARE_LO + $urandom_range(0, 2)), $urandom);
            n = $urandom_range(20, 120);
            pct = $urandom_range(5, 60);
            for (int i = 0; i < n; i++)
                onset_queue.push_back($urandom_range(0, 99) < pct);
            random_sent += n;
            drain();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_reverse_gate_swell_envelope_top passed");
        else
            $display("tb_reverse_gate_swell_envelope_top failed");
        $finish;
    end

endmodule
